// ----- src/irc_pkg.sv -----
// ----------------------------------------------------------------------------
// irc_pkg
// Shared sizes, operation codes and handshake structs for the running
// return covariance block.
// ----------------------------------------------------------------------------
package irc_pkg;

    localparam int ASSET_COUNT = 4;
    localparam int IDX_W       = (ASSET_COUNT > 1) ? $clog2(ASSET_COUNT) : 1;
    localparam int MAT_SIZE    = ASSET_COUNT * ASSET_COUNT;
    localparam int K_W         = $clog2(MAT_SIZE);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ASSET_COUNT - 1);
    localparam logic [K_W-1:0]   LAST_K   = K_W'(MAT_SIZE - 1);

    localparam logic [31:0] QNAN = 32'h7FC0_0000;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_CVT
    } fpu_op_t;

    typedef struct packed {
        logic        start;
        fpu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } fpu_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } fpu_rsp_t;

    typedef enum logic [3:0] {
        F_IDLE,
        F_PREP,
        F_MUL,
        F_DIV,
        F_DIVEND,
        F_ALIGN,
        F_ADD,
        F_NORM,
        F_ROUND,
        F_DONE
    } fpu_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CVT_OLD,
        S_CVT_TOT,
        S_DIFF,
        S_RET,
        S_MOLD,
        S_MADD,
        S_MDIV,
        S_SFETCH,
        S_SOLD,
        S_PRODA,
        S_PROD,
        S_SADD,
        S_SDIV,
        S_MMA,
        S_MM,
        S_SUB,
        S_EMIT
    } seq_state_t;

endpackage

// ----- src/irc_ram.sv -----
// ----------------------------------------------------------------------------
// irc_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module irc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/irc_fpu.sv -----
// ----------------------------------------------------------------------------
// irc_fpu
// Multi-cycle single precision unit: add, subtract, multiply, divide and
// unsigned integer convert, round to nearest even, subnormals kept.
// ----------------------------------------------------------------------------
module irc_fpu (
    input  logic              clk,
    input  logic              rst_n,
    input  irc_pkg::fpu_req_t req,
    output irc_pkg::fpu_rsp_t rsp
);

    irc_pkg::fpu_state_t state_reg;
    irc_pkg::fpu_state_t state_next;

    irc_pkg::fpu_op_t   op_reg;
    logic [31:0]        a_reg;
    logic [31:0]        b_reg;
    logic [23:0]        sa_reg;
    logic [23:0]        sb_reg;
    logic signed [10:0] ea_reg;
    logic signed [10:0] eb_reg;
    logic               sign_a_reg;
    logic               sign_b_reg;
    logic               sign_reg;
    logic               sub_reg;
    logic [49:0]        mant_reg;
    logic signed [10:0] exp_reg;
    logic [49:0]        x_reg;
    logic [49:0]        y_reg;
    logic [24:0]        rem_reg;
    logic [25:0]        q_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        res_reg;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        logic       found;
        n     = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--)
        begin
            if (!found)
            begin
                if (v[i])
                begin
                    found = 1'b1;
                end
                else
                begin
                    n = n + 5'd1;
                end
            end
        end
        return n;
    endfunction

    // operand decode
    logic [7:0]         a_exp, b_exp;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic               sa_eff, sb_eff, sx;
    logic [23:0]        a_sig, b_sig;
    logic [4:0]         a_lz, b_lz;
    logic signed [10:0] a_e, b_e;
    logic               special;
    logic [31:0]        special_res;

    always_comb
    begin
        a_exp  = a_reg[30:23];
        b_exp  = b_reg[30:23];
        a_nan  = (a_exp == 8'hFF) && (a_reg[22:0] != 23'd0);
        b_nan  = (b_exp == 8'hFF) && (b_reg[22:0] != 23'd0);
        a_inf  = (a_exp == 8'hFF) && (a_reg[22:0] == 23'd0);
        b_inf  = (b_exp == 8'hFF) && (b_reg[22:0] == 23'd0);
        a_zero = (a_reg[30:0] == 31'd0);
        b_zero = (b_reg[30:0] == 31'd0);
        sa_eff = a_reg[31];
        sb_eff = b_reg[31] ^ (op_reg == irc_pkg::OP_SUB);
        sx     = a_reg[31] ^ b_reg[31];
        a_sig  = {a_exp != 8'd0, a_reg[22:0]};
        b_sig  = {b_exp != 8'd0, b_reg[22:0]};
        a_lz   = lzc24(a_sig);
        b_lz   = lzc24(b_sig);
        a_e    = ((a_exp == 8'd0) ? -11'sd126 : ($signed({3'b000, a_exp}) - 11'sd127))
                 - $signed({6'd0, a_lz});
        b_e    = ((b_exp == 8'd0) ? -11'sd126 : ($signed({3'b000, b_exp}) - 11'sd127))
                 - $signed({6'd0, b_lz});

        special     = 1'b0;
        special_res = 32'd0;
        case (op_reg)
            irc_pkg::OP_ADD, irc_pkg::OP_SUB:
            begin
                special = 1'b1;
                if (a_nan || b_nan || (a_inf && b_inf && (sa_eff != sb_eff)))
                    special_res = irc_pkg::QNAN;
                else if (a_inf)
                    special_res = a_reg;
                else if (b_inf)
                    special_res = {sb_eff, b_reg[30:0]};
                else if (a_zero && b_zero)
                    special_res = {sa_eff & sb_eff, 31'd0};
                else if (a_zero)
                    special_res = {sb_eff, b_reg[30:0]};
                else if (b_zero)
                    special_res = a_reg;
                else
                    special = 1'b0;
            end
            irc_pkg::OP_MUL:
            begin
                special = 1'b1;
                if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf))
                    special_res = irc_pkg::QNAN;
                else if (a_inf || b_inf)
                    special_res = {sx, 8'hFF, 23'd0};
                else if (a_zero || b_zero)
                    special_res = {sx, 31'd0};
                else
                    special = 1'b0;
            end
            irc_pkg::OP_DIV:
            begin
                special = 1'b1;
                if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero))
                    special_res = irc_pkg::QNAN;
                else if (a_inf || b_zero)
                    special_res = {sx, 8'hFF, 23'd0};
                else if (b_inf || a_zero)
                    special_res = {sx, 31'd0};
                else
                    special = 1'b0;
            end
            default:
            begin
                special = 1'b0;
            end
        endcase
    end

    // alignment for add
    logic               a_big;
    logic signed [10:0] align_d;
    logic [49:0]        small_full;
    logic [49:0]        lost_mask;
    logic [49:0]        y_aligned;

    always_comb
    begin
        a_big      = (ea_reg > eb_reg) || ((ea_reg == eb_reg) && (sa_reg >= sb_reg));
        align_d    = a_big ? (ea_reg - eb_reg) : (eb_reg - ea_reg);
        small_full = {1'b0, (a_big ? sb_reg : sa_reg), 25'd0};
        lost_mask  = ~({50{1'b1}} << align_d[5:0]);
        if (align_d >= 11'sd50)
            y_aligned = 50'd1;
        else
            y_aligned = (small_full >> align_d[5:0])
                        | {49'd0, |(small_full & lost_mask)};
    end

    // full significand product
    logic [47:0] mul_full;

    assign mul_full = sa_reg * sb_reg;

    // divider step
    logic        div_ge;
    logic [24:0] div_diff;
    logic [24:0] div_keep;

    always_comb
    begin
        div_ge   = rem_reg >= {1'b0, sb_reg};
        div_diff = rem_reg - {1'b0, sb_reg};
        div_keep = div_ge ? div_diff : rem_reg;
    end

    // rounding and packing
    logic signed [10:0] biased;
    logic signed [10:0] den_shift;
    logic [49:0]        rnd_m;
    logic [49:0]        den_mask;
    logic [23:0]        rnd_sig;
    logic               rnd_g, rnd_s, rnd_inc;
    logic [7:0]         exp_part;
    logic [31:0]        packed_res;
    logic [31:0]        round_res;

    always_comb
    begin
        biased    = exp_reg + 11'sd127;
        den_shift = 11'sd1 - biased;
        den_mask  = ~({50{1'b1}} << den_shift[5:0]);
        if (biased >= 11'sd1)
            rnd_m = mant_reg;
        else if (den_shift >= 11'sd50)
            rnd_m = 50'd1;
        else
            rnd_m = (mant_reg >> den_shift[5:0]) | {49'd0, |(mant_reg & den_mask)};
        rnd_sig    = rnd_m[49:26];
        rnd_g      = rnd_m[25];
        rnd_s      = |rnd_m[24:0];
        rnd_inc    = rnd_g && (rnd_s || rnd_sig[0]);
        exp_part   = (biased >= 11'sd1) ? (biased[7:0] - 8'd1) : 8'd0;
        packed_res = {1'b0, exp_part, 23'd0} + {8'd0, rnd_sig} + {31'd0, rnd_inc};
        if (biased >= 11'sd255)
            round_res = {sign_reg, 8'hFF, 23'd0};
        else
            round_res = {sign_reg, packed_res[30:0]};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            irc_pkg::F_IDLE:
            begin
                if (req.start)
                    state_next = irc_pkg::F_PREP;
            end
            irc_pkg::F_PREP:
            begin
                if (special)
                    state_next = irc_pkg::F_DONE;
                else
                begin
                    case (op_reg)
                        irc_pkg::OP_MUL: state_next = irc_pkg::F_MUL;
                        irc_pkg::OP_DIV: state_next = irc_pkg::F_DIV;
                        irc_pkg::OP_CVT: state_next = irc_pkg::F_NORM;
                        default:         state_next = irc_pkg::F_ALIGN;
                    endcase
                end
            end
            irc_pkg::F_MUL:    state_next = irc_pkg::F_NORM;
            irc_pkg::F_DIV:
            begin
                if (cnt_reg == 5'd0)
                    state_next = irc_pkg::F_DIVEND;
            end
            irc_pkg::F_DIVEND: state_next = irc_pkg::F_NORM;
            irc_pkg::F_ALIGN:  state_next = irc_pkg::F_ADD;
            irc_pkg::F_ADD:    state_next = irc_pkg::F_NORM;
            irc_pkg::F_NORM:
            begin
                if (mant_reg == 50'd0)
                    state_next = irc_pkg::F_DONE;
                else if (mant_reg[49])
                    state_next = irc_pkg::F_ROUND;
            end
            irc_pkg::F_ROUND:  state_next = irc_pkg::F_DONE;
            irc_pkg::F_DONE:   state_next = irc_pkg::F_IDLE;
            default:           state_next = irc_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= irc_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            irc_pkg::F_IDLE:
            begin
                if (req.start)
                begin
                    op_reg <= req.op;
                    a_reg  <= req.a;
                    b_reg  <= req.b;
                end
            end
            irc_pkg::F_PREP:
            begin
                res_reg    <= special_res;
                sa_reg     <= a_sig << a_lz;
                sb_reg     <= b_sig << b_lz;
                ea_reg     <= a_e;
                eb_reg     <= b_e;
                sign_a_reg <= sa_eff;
                sign_b_reg <= sb_eff;
                sign_reg   <= (op_reg == irc_pkg::OP_CVT) ? 1'b0 : sx;
                rem_reg    <= {1'b0, a_sig << a_lz};
                q_reg      <= 26'd0;
                cnt_reg    <= 5'd25;
                if (op_reg == irc_pkg::OP_CVT)
                begin
                    mant_reg <= {a_reg, 18'd0};
                    exp_reg  <= 11'sd31;
                end
            end
            irc_pkg::F_MUL:
            begin
                mant_reg <= {mul_full, 2'b00};
                exp_reg  <= ea_reg + eb_reg + 11'sd1;
            end
            irc_pkg::F_DIV:
            begin
                q_reg   <= {q_reg[24:0], div_ge};
                rem_reg <= {div_keep[23:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
            end
            irc_pkg::F_DIVEND:
            begin
                mant_reg <= {q_reg, 23'd0, rem_reg != 25'd0};
                exp_reg  <= ea_reg - eb_reg;
            end
            irc_pkg::F_ALIGN:
            begin
                x_reg    <= {1'b0, (a_big ? sa_reg : sb_reg), 25'd0};
                y_reg    <= y_aligned;
                exp_reg  <= (a_big ? ea_reg : eb_reg) + 11'sd1;
                sign_reg <= a_big ? sign_a_reg : sign_b_reg;
                sub_reg  <= sign_a_reg ^ sign_b_reg;
            end
            irc_pkg::F_ADD:
            begin
                mant_reg <= sub_reg ? (x_reg - y_reg) : (x_reg + y_reg);
            end
            irc_pkg::F_NORM:
            begin
                // exact cancellation and zero convert give +0
                if (mant_reg == 50'd0)
                    res_reg <= 32'd0;
                else if (!mant_reg[49])
                begin
                    if (mant_reg[49:42] == 8'd0)
                    begin
                        mant_reg <= mant_reg << 8;
                        exp_reg  <= exp_reg - 11'sd8;
                    end
                    else
                    begin
                        mant_reg <= mant_reg << 1;
                        exp_reg  <= exp_reg - 11'sd1;
                    end
                end
            end
            irc_pkg::F_ROUND:
            begin
                res_reg <= round_res;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done   = (state_reg == irc_pkg::F_DONE);
    assign rsp.result = res_reg;

endmodule

// ----- src/incremental_return_covariance.sv -----
// ----------------------------------------------------------------------------
// incremental_return_covariance
// Running covariance of simple returns over snapshots of asset prices.
//
//   channel | direction | fields               | handshake
//   price   | in        | price_bits           | price_valid / price_stall
//   cov     | out       | cov_bits, matrix_end | cov_valid / cov_stall
//
// A price item is taken when it is valid and the input is not stalled; the
// item that completes a snapshot (after the first) starts the update and
// stalls the input until the last matrix entry is in the output register.
// The update runs on the single shared float unit, whose divide walks one
// quotient bit per cycle. Reset clears the sequencer, slot and snapshot
// count; no clearing pass.
// ----------------------------------------------------------------------------
module incremental_return_covariance (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        price_valid,
    output logic        price_stall,
    input  logic [31:0] price_bits,
    output logic        cov_valid,
    input  logic        cov_stall,
    output logic [31:0] cov_bits,
    output logic        matrix_end
);

    irc_pkg::seq_state_t state_reg;
    irc_pkg::seq_state_t state_next;

    logic                      wait_reg;
    logic [irc_pkg::IDX_W-1:0] slot_reg;
    logic [irc_pkg::IDX_W-1:0] i_reg;
    logic [irc_pkg::IDX_W-1:0] j_reg;
    logic [irc_pkg::K_W-1:0]   k_reg;
    logic [31:0]               count_reg;
    logic                      cov_valid_reg;
    logic [31:0]               cov_bits_reg;
    logic                      matrix_end_reg;

    logic [31:0] prev_reg [irc_pkg::ASSET_COUNT];
    logic [31:0] inc_reg  [irc_pkg::ASSET_COUNT];
    logic [31:0] mean_reg [irc_pkg::ASSET_COUNT];
    logic [31:0] r_reg    [irc_pkg::ASSET_COUNT];
    logic [31:0] older_reg;
    logic [31:0] total_reg;
    logic [31:0] t_reg;
    logic [31:0] u_reg;
    logic [31:0] p_reg;
    logic [31:0] s_reg;
    logic [31:0] c_reg;

    irc_pkg::fpu_req_t fpu_req;
    irc_pkg::fpu_rsp_t fpu_rsp;

    logic                      accept;
    logic                      first;
    logic                      calc;
    logic                      done;
    logic                      out_free;
    logic [irc_pkg::IDX_W-1:0] rd_idx;
    logic [31:0]               mean_rd;
    logic [31:0]               r_rd;
    logic [31:0]               sm_rd;
    logic                      sm_wr;

    assign price_stall = (state_reg != irc_pkg::S_IDLE);
    assign accept      = price_valid && !price_stall;
    // second moments and means read as zero on the first update
    assign first       = (count_reg == 32'd1);
    assign done        = fpu_rsp.done;
    assign out_free    = !cov_valid_reg || !cov_stall;
    assign rd_idx      = ((state_reg == irc_pkg::S_PROD) || (state_reg == irc_pkg::S_MM))
                         ? j_reg : i_reg;
    assign mean_rd     = mean_reg[rd_idx];
    assign r_rd        = r_reg[rd_idx];
    assign sm_wr       = (state_reg == irc_pkg::S_SDIV) && done;

    irc_ram #(
        .WIDTH (32),
        .DEPTH (irc_pkg::MAT_SIZE)
    ) u_moment_ram (
        .clk     (clk),
        .wr_en   (sm_wr),
        .wr_addr (k_reg),
        .wr_data (fpu_rsp.result),
        .rd_addr (k_reg),
        .rd_data (sm_rd)
    );

    irc_fpu u_fpu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fpu_req),
        .rsp   (fpu_rsp)
    );

    always_comb
    begin
        calc       = 1'b1;
        fpu_req.op = irc_pkg::OP_ADD;
        fpu_req.a  = t_reg;
        fpu_req.b  = p_reg;
        case (state_reg)
            irc_pkg::S_CVT_OLD:
            begin
                fpu_req.op = irc_pkg::OP_CVT;
                fpu_req.a  = count_reg - 32'd1;
            end
            irc_pkg::S_CVT_TOT:
            begin
                fpu_req.op = irc_pkg::OP_CVT;
                fpu_req.a  = count_reg;
            end
            irc_pkg::S_DIFF:
            begin
                fpu_req.op = irc_pkg::OP_SUB;
                fpu_req.a  = inc_reg[i_reg];
                fpu_req.b  = prev_reg[i_reg];
            end
            irc_pkg::S_RET:
            begin
                fpu_req.op = irc_pkg::OP_DIV;
                fpu_req.b  = prev_reg[i_reg];
            end
            irc_pkg::S_MOLD:
            begin
                fpu_req.op = irc_pkg::OP_MUL;
                fpu_req.a  = older_reg;
                fpu_req.b  = first ? 32'd0 : mean_rd;
            end
            irc_pkg::S_MADD:
            begin
                fpu_req.b = r_rd;
            end
            irc_pkg::S_MDIV, irc_pkg::S_SDIV:
            begin
                fpu_req.op = irc_pkg::OP_DIV;
                fpu_req.b  = total_reg;
            end
            irc_pkg::S_SOLD:
            begin
                fpu_req.op = irc_pkg::OP_MUL;
                fpu_req.a  = older_reg;
                fpu_req.b  = first ? 32'd0 : sm_rd;
            end
            irc_pkg::S_PROD:
            begin
                fpu_req.op = irc_pkg::OP_MUL;
                fpu_req.a  = u_reg;
                fpu_req.b  = r_rd;
            end
            irc_pkg::S_SADD:
            begin
                fpu_req.op = irc_pkg::OP_ADD;
            end
            irc_pkg::S_MM:
            begin
                fpu_req.op = irc_pkg::OP_MUL;
                fpu_req.a  = u_reg;
                fpu_req.b  = mean_rd;
            end
            irc_pkg::S_SUB:
            begin
                fpu_req.op = irc_pkg::OP_SUB;
                fpu_req.a  = s_reg;
            end
            default:
            begin
                calc = 1'b0;
            end
        endcase
        fpu_req.start = calc && !wait_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            irc_pkg::S_IDLE:
            begin
                if (accept && (slot_reg == irc_pkg::LAST_IDX) && (count_reg != 32'd0))
                    state_next = irc_pkg::S_CVT_OLD;
            end
            irc_pkg::S_CVT_OLD: if (done) state_next = irc_pkg::S_CVT_TOT;
            irc_pkg::S_CVT_TOT: if (done) state_next = irc_pkg::S_DIFF;
            irc_pkg::S_DIFF:    if (done) state_next = irc_pkg::S_RET;
            irc_pkg::S_RET:     if (done) state_next = irc_pkg::S_MOLD;
            irc_pkg::S_MOLD:    if (done) state_next = irc_pkg::S_MADD;
            irc_pkg::S_MADD:    if (done) state_next = irc_pkg::S_MDIV;
            irc_pkg::S_MDIV:
            begin
                if (done)
                    state_next = (i_reg == irc_pkg::LAST_IDX) ? irc_pkg::S_SFETCH
                                                              : irc_pkg::S_DIFF;
            end
            irc_pkg::S_SFETCH:  state_next = irc_pkg::S_SOLD;
            irc_pkg::S_SOLD:    if (done) state_next = irc_pkg::S_PRODA;
            irc_pkg::S_PRODA:   state_next = irc_pkg::S_PROD;
            irc_pkg::S_PROD:    if (done) state_next = irc_pkg::S_SADD;
            irc_pkg::S_SADD:    if (done) state_next = irc_pkg::S_SDIV;
            irc_pkg::S_SDIV:    if (done) state_next = irc_pkg::S_MMA;
            irc_pkg::S_MMA:     state_next = irc_pkg::S_MM;
            irc_pkg::S_MM:      if (done) state_next = irc_pkg::S_SUB;
            irc_pkg::S_SUB:     if (done) state_next = irc_pkg::S_EMIT;
            irc_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = (k_reg == irc_pkg::LAST_K) ? irc_pkg::S_IDLE
                                                            : irc_pkg::S_SFETCH;
            end
            default:            state_next = irc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= irc_pkg::S_IDLE;
            wait_reg      <= 1'b0;
            slot_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            count_reg     <= 32'd0;
            cov_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (done)
                wait_reg <= 1'b0;
            else if (fpu_req.start)
                wait_reg <= 1'b1;

            if (accept)
            begin
                if (slot_reg == irc_pkg::LAST_IDX)
                begin
                    slot_reg <= '0;
                    if (count_reg == 32'd0)
                        count_reg <= 32'd1;
                end
                else
                begin
                    slot_reg <= slot_reg + 1'b1;
                end
            end

            if ((state_reg == irc_pkg::S_MDIV) && done)
                i_reg <= (i_reg == irc_pkg::LAST_IDX) ? '0 : i_reg + 1'b1;

            if ((state_reg == irc_pkg::S_EMIT) && out_free)
            begin
                cov_valid_reg <= 1'b1;
                if (k_reg == irc_pkg::LAST_K)
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    k_reg <= '0;
                    if (count_reg != 32'hFFFF_FFFF)
                        count_reg <= count_reg + 32'd1;
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                    if (j_reg == irc_pkg::LAST_IDX)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
            end
            else if (!cov_stall)
            begin
                cov_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inc_reg[slot_reg] <= price_bits;
            // first snapshot goes straight to the old prices
            if (count_reg == 32'd0)
                prev_reg[slot_reg] <= price_bits;
        end

        if (done)
        begin
            case (state_reg)
                irc_pkg::S_CVT_OLD: older_reg <= fpu_rsp.result;
                irc_pkg::S_CVT_TOT: total_reg <= fpu_rsp.result;
                irc_pkg::S_RET:
                begin
                    r_reg[i_reg]    <= fpu_rsp.result;
                    prev_reg[i_reg] <= inc_reg[i_reg];
                end
                irc_pkg::S_MDIV:    mean_reg[i_reg] <= fpu_rsp.result;
                irc_pkg::S_PROD,
                irc_pkg::S_MM:      p_reg <= fpu_rsp.result;
                irc_pkg::S_SDIV:    s_reg <= fpu_rsp.result;
                irc_pkg::S_SUB:     c_reg <= fpu_rsp.result;
                default:            t_reg <= fpu_rsp.result;
            endcase
        end

        if (state_reg == irc_pkg::S_PRODA)
            u_reg <= r_rd;
        else if (state_reg == irc_pkg::S_MMA)
            u_reg <= mean_rd;

        if ((state_reg == irc_pkg::S_EMIT) && out_free)
        begin
            cov_bits_reg   <= c_reg;
            matrix_end_reg <= (k_reg == irc_pkg::LAST_K);
        end
    end

    assign cov_valid  = cov_valid_reg;
    assign cov_bits   = cov_bits_reg;
    assign matrix_end = matrix_end_reg;

endmodule

// ----- tb/sv/incremental_return_covariance_test.sv -----
// ----------------------------------------------------------------------------
// incremental_return_covariance_test
// Self-checking bench for the running return covariance block. Price words
// go in as snapshots of one price per asset. A scoreboard class predicts each
// covariance matrix in single precision and checks every output entry in
// order. Both sides idle at random, and the output holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module incremental_return_covariance_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 2500;

    class covariance_scoreboard;
        logic [31:0] prev_px [irc_pkg::ASSET_COUNT];
        logic [31:0] next_px [irc_pkg::ASSET_COUNT];
        logic [31:0] mean_ret [irc_pkg::ASSET_COUNT];
        logic [31:0] moment [irc_pkg::MAT_SIZE];
        int unsigned slot;
        logic [31:0] snap_count;
        logic [31:0] want_cov [$];
        logic        want_end [$];
        int          errors;
        int          checked;
        int          matrices;

        function new();
            for (int i = 0; i < irc_pkg::ASSET_COUNT; i++)
            begin
                prev_px[i]  = '0;
                next_px[i]  = '0;
                mean_ret[i] = '0;
            end
            for (int i = 0; i < irc_pkg::MAT_SIZE; i++)
                moment[i] = '0;
            slot       = 0;
            snap_count = '0;
            errors     = 0;
            checked    = 0;
            matrices   = 0;
        endfunction

        static function bit is_nan(logic [31:0] b);
            return b[30:23] == 8'hFF && b[22:0] != 0;
        endfunction

        static function real to_real(logic [31:0] b);
            real r;
            if (b[30:23] == 8'hFF)
                return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'b0});
            if (b[30:23] == 0)
            begin
                if (b[22:0] == 0)
                    return $bitstoreal({b[31], 63'b0});
                r = b[22:0];
                r = r / (2.0 ** 149);
                return b[31] ? -r : r;
            end
            return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'b0});
        endfunction

        // round a double to single, nearest even; the double result of one
        // single op is exact enough that this second rounding is harmless
        static function logic [31:0] to_single(real x);
            logic [63:0] d;
            logic [63:0] sig;
            logic [63:0] kept;
            logic [63:0] rest;
            logic [63:0] half;
            longint      val;
            int          ue;
            int          sh;
            d = $realtobits(x);
            if (d[62:52] == 11'h7FF)
                return (d[51:0] != 0) ? irc_pkg::QNAN : {d[63], 8'hFF, 23'b0};
            if (d[62:52] == 0)
                return {d[63], 31'b0};
            ue  = int'(d[62:52]) - 1023;
            sig = {11'b0, 1'b1, d[51:0]};
            sh  = (ue >= -126) ? 29 : 29 + (-126 - ue);
            if (sh > 60)
                return {d[63], 31'b0};
            kept = sig >> sh;
            rest = sig & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rest > half || (rest == half && kept[0]))
                kept = kept + 1;
            if (ue < -126)
                return {d[63], kept[30:0]};
            val = longint'(ue + 127) * 64'h800000 + longint'(kept) - 64'h800000;
            if (val >= 255 * 64'h800000)
                return {d[63], 8'hFF, 23'b0};
            return {d[63], val[30:0]};
        endfunction

        static function logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
            return to_single(to_real(a) + to_real(b));
        endfunction

        static function logic [31:0] f_sub(logic [31:0] a, logic [31:0] b);
            return to_single(to_real(a) - to_real(b));
        endfunction

        static function logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
            return to_single(to_real(a) * to_real(b));
        endfunction

        static function logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
            if (b[30:0] == 0)
            begin
                if (is_nan(a) || a[30:0] == 0)
                    return irc_pkg::QNAN;
                return {a[31] ^ b[31], 8'hFF, 23'b0};
            end
            return to_single(to_real(a) / to_real(b));
        endfunction

        function void note_price(logic [31:0] px);
            logic [31:0] ret [irc_pkg::ASSET_COUNT];
            logic [31:0] older;
            logic [31:0] total;
            logic [31:0] t;
            logic [31:0] c;
            int          k;
            next_px[slot] = px;
            slot++;
            if (slot < irc_pkg::ASSET_COUNT)
                return;
            slot = 0;
            if (snap_count == 0)
            begin
                prev_px    = next_px;
                snap_count = 1;
                return;
            end
            older = to_single(real'(longint'(snap_count) - 1));
            total = to_single(real'(longint'(snap_count)));
            for (int i = 0; i < irc_pkg::ASSET_COUNT; i++)
            begin
                ret[i]      = f_div(f_sub(next_px[i], prev_px[i]), prev_px[i]);
                t           = f_add(f_mul(older, mean_ret[i]), ret[i]);
                mean_ret[i] = f_div(t, total);
            end
            for (int i = 0; i < irc_pkg::ASSET_COUNT; i++)
                for (int j = 0; j < irc_pkg::ASSET_COUNT; j++)
                begin
                    k         = i * irc_pkg::ASSET_COUNT + j;
                    t         = f_add(f_mul(older, moment[k]), f_mul(ret[i], ret[j]));
                    moment[k] = f_div(t, total);
                    c = f_sub(moment[k], f_mul(mean_ret[i], mean_ret[j]));
                    want_cov.push_back(is_nan(c) ? irc_pkg::QNAN : c);
                    want_end.push_back(k == irc_pkg::MAT_SIZE - 1);
                end
            prev_px = next_px;
            matrices++;
            if (snap_count != 32'hFFFF_FFFF)
                snap_count++;
        endfunction

        function void check_entry(logic [31:0] cov, logic last);
            logic [31:0] w_cov;
            logic        w_end;
            if (want_cov.size() == 0)
            begin
                $error("unexpected entry cov_bits=%h matrix_end=%b", cov, last);
                errors++;
                return;
            end
            w_cov = want_cov.pop_front();
            w_end = want_end.pop_front();
            checked++;
            if (cov !== w_cov)
            begin
                $error("cov_bits: expected %h, got %h", w_cov, cov);
                errors++;
            end
            if (last !== w_end)
            begin
                $error("matrix_end: expected %b, got %b", w_end, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        price_valid;
    logic        price_stall;
    logic [31:0] price_bits;
    logic        cov_valid;
    logic        cov_stall;
    logic [31:0] cov_bits;
    logic        matrix_end;

    covariance_scoreboard sb;
    bit in_calm;
    bit out_calm;
    int prices_sent;
    longint cycles;

    incremental_return_covariance u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .price_valid (price_valid),
        .price_stall (price_stall),
        .price_bits  (price_bits),
        .cov_valid   (cov_valid),
        .cov_stall   (cov_stall),
        .cov_bits    (cov_bits),
        .matrix_end  (matrix_end)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // offer one price item and wait until it is taken
    task send_price(input logic [31:0] px);
        while (!in_calm && $urandom_range(0, 99) < 12)
        begin
            price_valid <= 1'b0;
            @(negedge clk);
        end
        price_valid <= 1'b1;
        price_bits  <= px;
        @(posedge clk);
        while (price_stall)
            @(posedge clk);
        sb.note_price(px);
        prices_sent++;
        @(negedge clk);
    endtask

    task send_group(input logic [31:0] a, input logic [31:0] b,
                    input logic [31:0] c, input logic [31:0] d);
        send_price(a);
        send_price(b);
        send_price(c);
        send_price(d);
    endtask

    function logic [31:0] market_price();
        real p;
        p = 20.0 + $urandom_range(0, 200000) / 1000.0;
        return covariance_scoreboard::to_single(p);
    endfunction

    // output side: random stalls, one long hold-off once some results are in
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        @(negedge clk);
        forever
        begin
            @(posedge clk);
            if (rst_n && cov_valid && !cov_stall)
                sb.check_entry(cov_bits, matrix_end);
            @(negedge clk);
            if (!held && sb.checked >= 60)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                cov_stall <= 1'b1;
            end
            else
                cov_stall <= !out_calm && ($urandom_range(0, 99) < 12);
        end
    end

    initial
    begin
        int n;
        sb          = new();
        in_calm     = 1'b0;
        out_calm    = 1'b0;
        prices_sent = 0;
        rst_n       = 1'b0;
        price_valid = 1'b0;
        price_bits  = '0;
        cov_stall   = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // finite extremes: first group is only stored
        send_group(32'h42C8_0000, 32'h3F80_0000, 32'hC120_0000, 32'h4000_0000);
        send_group(32'h42CA_0000, 32'h3F80_0000, 32'hC100_0000, 32'h3F00_0000);
        send_group(32'h7F7F_FFFF, 32'h0080_0000, 32'h0000_0100, 32'hFF00_0000);
        send_group(32'h7F00_0000, 32'h0100_0000, 32'h0000_0300, 32'hFF7F_FFFF);
        send_group(32'h7F00_0000, 32'h0100_0000, 32'h0000_0300, 32'hFF7F_FFFF);
        send_group(32'h3DCC_CCCD, 32'h4B80_0001, 32'h0000_0001, 32'hBF80_0000);

        // random market groups, with a calm stretch on both sides
        for (n = 0; n < 14; n++)
        begin
            in_calm  = (n >= 4 && n < 9);
            out_calm = (n >= 6 && n < 12);
            send_group(market_price(), market_price(), market_price(), market_price());
        end
        in_calm  = 1'b0;
        out_calm = 1'b0;

        // zero old prices, nan and infinity; these poison the moments so go last
        send_group(32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h40A0_0000);
        send_group(32'h4040_0000, 32'h0000_0000, 32'hC000_0000, 32'h7FC0_0001);
        send_group(32'h7F80_0000, 32'h3F80_0000, 32'h40E0_0000, 32'hFFFF_FFFF);
        for (n = 0; n < 4; n++)
            send_group($urandom, $urandom, $urandom, $urandom);
        send_group(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        send_price(32'h1234_5678);
        price_valid <= 1'b0;

        while (sb.want_cov.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);

        $display("sent %0d prices, %0d matrices predicted, %0d entries checked",
                 prices_sent, sb.matrices, sb.checked);
        $display("covered float extremes, zero old prices, nan and infinity, long output hold");
        if (sb.errors == 0 && sb.want_cov.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
src/irc_pkg.sv
src/irc_ram.sv
src/irc_fpu.sv
src/incremental_return_covariance.sv
tb/sv/incremental_return_covariance_test.sv
